// ----- sv/ssp_pkg.sv -----
// shared types, constants and helpers of the strobe stripe pattern generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

  localparam int HEIGHT      = 720;
  localparam int PAL_DEPTH   = 64;
  localparam int PAL_IDX_W   = $clog2(PAL_DEPTH);
  localparam int SIZE_W      = 7;
  localparam int COL_W       = 11;
  localparam int ROW_W       = 10;
  localparam int LVL_W       = 4;
  localparam int HOLD_W      = 6;
  localparam int SCROLL_W    = 7;
  localparam int COLOR_W     = 32;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_IDX_W   = 1;

  localparam int SCROLL_WRAP = 120;
  localparam int HOLD_MAX    = 60;
  localparam int HOLD_MIN    = 1;
  localparam int HOLD_RESET  = 10;
  localparam int LEVEL_MAX   = 15;
  localparam int SIZE_RESET  = 8;

  // row mapping y = (r + scroll + ROW_OFS) mod HEIGHT
  localparam int ROW_OFS  = HEIGHT - SCROLL_WRAP;
  localparam int SUM_MAX  = (2 ** ROW_W - 1) + (SCROLL_WRAP - 1) + ROW_OFS;
  localparam int SUM_W    = $clog2(SUM_MAX + 1);
  localparam int Y_SUBS   = SUM_MAX / HEIGHT;
  localparam int Y_W      = $clog2(HEIGHT);

  // stripe index floor((3x + 4y) / 240) = floor((s >> 4) / 15)
  localparam int STRIPE_W = $clog2(3 * (2 ** COL_W - 1) + 4 * (HEIGHT - 1) + 1);
  localparam int STRIPE_T_W = STRIPE_W - 4;
  localparam int RECIP      = 2185;
  localparam int RECIP_W    = 12;
  localparam int RECIP_SH   = 15;
  localparam int PROD_W     = STRIPE_T_W + RECIP_W;

  typedef enum logic [1:0] {
    REQ_FRAME   = 2'd0,
    REQ_PIXEL   = 2'd1,
    REQ_PALETTE = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    CMD_NONE       = 4'd0,
    CMD_RESET_TIME = 4'd1,
    CMD_HOLD_UP    = 4'd2,
    CMD_HOLD_DN    = 4'd3,
    CMD_LVL_A_MAX  = 4'd4,
    CMD_LVL_B_MAX  = 4'd5,
    CMD_IDX_A_UP   = 4'd6,
    CMD_IDX_A_DN   = 4'd7,
    CMD_IDX_B_UP   = 4'd8,
    CMD_IDX_B_DN   = 4'd9,
    CMD_LVL_A_UP   = 4'd10,
    CMD_LVL_A_DN   = 4'd11,
    CMD_LVL_B_UP   = 4'd12,
    CMD_LVL_B_DN   = 4'd13,
    CMD_STRIPES    = 4'd14
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PALETTE_SIZE = 1'd0,
    REG_SCALE        = 1'd1
  } reg_e;

  // pattern state seen by the pixel path
  typedef struct packed {
    logic [PAL_IDX_W-1:0] first_index;
    logic [PAL_IDX_W-1:0] second_index;
    logic [LVL_W-1:0]     first_level;
    logic [LVL_W-1:0]     second_level;
    logic                 phase;
    logic                 stripes_on;
    logic [SCROLL_W-1:0]  scroll;
  } pat_state_t;

  function automatic logic [COLOR_W-1:0] default_color(input logic [PAL_IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      6'd1:    c = 32'h0000_0011;
      6'd2:    c = 32'h0000_1111;
      6'd3:    c = 32'h0000_1100;
      6'd4:    c = 32'h0011_1100;
      6'd5:    c = 32'h0011_0000;
      6'd6:    c = 32'h0011_0011;
      6'd7:    c = 32'h0011_1111;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/strobe_stripe_pattern_generator_top.sv -----
// top level of the strobe stripe pattern generator
// instantiates ssp_ctrl, ssp_palette and ssp_pixel; uses ssp_pkg
//
// Usage: one input channel (in_valid_i / in_stall_o) carries beats of three kinds.
// A frame beat applies its command and advances frame counter, scroll and phase.
// A pixel beat returns one pixel_color_o beat on the output channel
// (out_valid_o / out_stall_i). A palette beat writes one colour entry.
// Frame and palette beats give no output beat.
// A pixel beat is presented once it has passed pipeline stages 1 to 5 in order.
// Throughput: one beat per cycle of any kind while in_stall_o is low; pixel
// beats run through a five-register pipeline whose first stage is the palette
// read port, both candidate colours being read at accept.
// Reset: pattern state, configuration and palette go to their defaults at once;
// palette entries read their default colour until first written.
// Stall: when the output is stalled the pipeline closes its bubbles and then
// raises in_stall_o; a beat already accepted is never dropped.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) must be written only while idle (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module strobe_stripe_pattern_generator_top (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [ssp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [ssp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [1:0]                     req_type_i,
  input  wire  [3:0]                     command_i,
  input  wire  [ssp_pkg::COL_W-1:0]      column_i,
  input  wire  [ssp_pkg::ROW_W-1:0]      display_row_i,
  input  wire  [ssp_pkg::PAL_IDX_W-1:0]  entry_index_i,
  input  wire  [ssp_pkg::COLOR_W-1:0]    entry_value_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [ssp_pkg::COLOR_W-1:0]    pixel_color_o
);
  import ssp_pkg::*;

  logic [SIZE_W-1:0] palette_size_q;
  logic              scale_q;
  logic              take;
  logic              acc;
  logic              acc_frame, acc_pix, acc_pal;
  pat_state_t        state;
  logic [COLOR_W-1:0] color_a, color_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_size_q <= SIZE_W'(SIZE_RESET);
      scale_q        <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_PALETTE_SIZE: palette_size_q <= cfg_data_i[SIZE_W-1:0];
        REG_SCALE:        scale_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !take;
  assign acc        = in_valid_i && take;
  assign acc_frame  = acc && (req_e'(req_type_i) == REQ_FRAME);
  assign acc_pix    = acc && (req_e'(req_type_i) == REQ_PIXEL);
  assign acc_pal    = acc && (req_e'(req_type_i) == REQ_PALETTE);

  ssp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_i        (acc_frame),
    .command_i      (command_i),
    .palette_size_i (palette_size_q),
    .state_o        (state)
  );

  ssp_palette u_palette (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (acc_pal),
    .wr_addr_i   (entry_index_i),
    .wr_data_i   (entry_value_i),
    .rd_en_i     (acc_pix),
    .rd_addr_a_i (state.first_index),
    .rd_addr_b_i (state.second_index),
    .rd_data_a_o (color_a),
    .rd_data_b_o (color_b)
  );

  ssp_pixel u_pixel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_i         (acc_pix),
    .column_i      (column_i),
    .display_row_i (display_row_i),
    .state_i       (state),
    .color_a_i     (color_a),
    .color_b_i     (color_b),
    .scale_i       (scale_q),
    .take_o        (take),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_color_o (pixel_color_o)
  );

endmodule

`default_nettype wire

// ----- sv/ssp_palette.sv -----
// palette memory, one write port and two registered read ports
// entries not yet written read as their reset colour; uses ssp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssp_palette (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         wr_en_i,
  input  wire  [ssp_pkg::PAL_IDX_W-1:0] wr_addr_i,
  input  wire  [ssp_pkg::COLOR_W-1:0]   wr_data_i,
  input  wire                         rd_en_i,
  input  wire  [ssp_pkg::PAL_IDX_W-1:0] rd_addr_a_i,
  input  wire  [ssp_pkg::PAL_IDX_W-1:0] rd_addr_b_i,
  output logic [ssp_pkg::COLOR_W-1:0]   rd_data_a_o,
  output logic [ssp_pkg::COLOR_W-1:0]   rd_data_b_o
);
  import ssp_pkg::*;

  logic [COLOR_W-1:0]   mem_q [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] vld_q;
  logic [COLOR_W-1:0]   rd_a_q;
  logic [COLOR_W-1:0]   rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= vld_q[rd_addr_a_i] ? mem_q[rd_addr_a_i] : default_color(rd_addr_a_i);
      rd_b_q <= vld_q[rd_addr_b_i] ? mem_q[rd_addr_b_i] : default_color(rd_addr_b_i);
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

`default_nettype wire

// ----- sv/ssp_ctrl.sv -----
// pattern state: command decode, frame counter, scroll and phase
// uses ssp_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssp_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      frame_i,
  input  wire  [3:0]               command_i,
  input  wire  [ssp_pkg::SIZE_W-1:0] palette_size_i,
  output ssp_pkg::pat_state_t      state_o
);
  import ssp_pkg::*;

  logic [HOLD_W-1:0]    frame_count_q, frame_count_d;
  logic [HOLD_W-1:0]    hold_q, hold_d;
  logic [PAL_IDX_W-1:0] idx_a_q, idx_a_d;
  logic [PAL_IDX_W-1:0] idx_b_q, idx_b_d;
  logic [LVL_W-1:0]     lvl_a_q, lvl_a_d;
  logic [LVL_W-1:0]     lvl_b_q, lvl_b_d;
  logic                 phase_q, phase_d;
  logic                 stripes_q, stripes_d;
  logic [SCROLL_W-1:0]  scroll_q, scroll_d;
  logic [SIZE_W-1:0]    eff_size;
  logic [HOLD_W-1:0]    fc_cmd;
  logic [HOLD_W:0]      fc_next;
  logic [HOLD_W:0]      hold_p1;

  function automatic logic [PAL_IDX_W-1:0] step_up(input logic [PAL_IDX_W-1:0] idx,
                                                   input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] nx;
    nx = SIZE_W'(idx) + 1'b1;
    return (nx >= sz) ? '0 : PAL_IDX_W'(nx);
  endfunction

  function automatic logic [PAL_IDX_W-1:0] step_dn(input logic [PAL_IDX_W-1:0] idx,
                                                   input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] last;
    last = sz - 1'b1;
    return (idx == '0 || SIZE_W'(idx) >= sz) ? PAL_IDX_W'(last) : idx - 1'b1;
  endfunction

  always_comb begin
    if (palette_size_i == '0) begin
      eff_size = SIZE_W'(1);
    end else if (palette_size_i > SIZE_W'(PAL_DEPTH)) begin
      eff_size = SIZE_W'(PAL_DEPTH);
    end else begin
      eff_size = palette_size_i;
    end
  end

  always_comb begin
    hold_d    = hold_q;
    idx_a_d   = idx_a_q;
    idx_b_d   = idx_b_q;
    lvl_a_d   = lvl_a_q;
    lvl_b_d   = lvl_b_q;
    stripes_d = stripes_q;
    fc_cmd    = frame_count_q;
    unique case (cmd_e'(command_i))
      CMD_RESET_TIME: begin
        hold_d = HOLD_W'(HOLD_RESET);
        fc_cmd = '0;
      end
      CMD_HOLD_UP:   if (hold_q < HOLD_W'(HOLD_MAX)) hold_d = hold_q + 1'b1;
      CMD_HOLD_DN:   if (hold_q > HOLD_W'(HOLD_MIN)) hold_d = hold_q - 1'b1;
      CMD_LVL_A_MAX: lvl_a_d = LVL_W'(LEVEL_MAX);
      CMD_LVL_B_MAX: lvl_b_d = LVL_W'(LEVEL_MAX);
      CMD_IDX_A_UP:  idx_a_d = step_up(idx_a_q, eff_size);
      CMD_IDX_A_DN:  idx_a_d = step_dn(idx_a_q, eff_size);
      CMD_IDX_B_UP:  idx_b_d = step_up(idx_b_q, eff_size);
      CMD_IDX_B_DN:  idx_b_d = step_dn(idx_b_q, eff_size);
      CMD_LVL_A_UP:  if (lvl_a_q < LVL_W'(LEVEL_MAX)) lvl_a_d = lvl_a_q + 1'b1;
      CMD_LVL_A_DN:  if (lvl_a_q > '0) lvl_a_d = lvl_a_q - 1'b1;
      CMD_LVL_B_UP:  if (lvl_b_q < LVL_W'(LEVEL_MAX)) lvl_b_d = lvl_b_q + 1'b1;
      CMD_LVL_B_DN:  if (lvl_b_q > '0) lvl_b_d = lvl_b_q - 1'b1;
      CMD_STRIPES:   stripes_d = ~stripes_q;
      default: ;
    endcase

    hold_p1 = {1'b0, hold_d} + 1'b1;
    fc_next = {1'b0, fc_cmd} + 1'b1;
    if (fc_next >= hold_p1) begin
      fc_next = fc_next - hold_p1;
    end
    frame_count_d = fc_next[HOLD_W-1:0];
    scroll_d = (scroll_q == SCROLL_W'(SCROLL_WRAP - 1)) ? '0 : scroll_q + 1'b1;
    phase_d  = (frame_count_d == '0) ? ~phase_q : phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= '0;
      hold_q        <= HOLD_W'(HOLD_RESET);
      idx_a_q       <= PAL_IDX_W'(1);
      idx_b_q       <= PAL_IDX_W'(3);
      lvl_a_q       <= LVL_W'(LEVEL_MAX);
      lvl_b_q       <= LVL_W'(LEVEL_MAX);
      phase_q       <= 1'b1;
      stripes_q     <= 1'b1;
      scroll_q      <= '0;
    end else if (frame_i) begin
      frame_count_q <= frame_count_d;
      hold_q        <= hold_d;
      idx_a_q       <= idx_a_d;
      idx_b_q       <= idx_b_d;
      lvl_a_q       <= lvl_a_d;
      lvl_b_q       <= lvl_b_d;
      phase_q       <= phase_d;
      stripes_q     <= stripes_d;
      scroll_q      <= scroll_d;
    end
  end

  assign state_o.first_index  = idx_a_q;
  assign state_o.second_index = idx_b_q;
  assign state_o.first_level  = lvl_a_q;
  assign state_o.second_level = lvl_b_q;
  assign state_o.phase        = phase_q;
  assign state_o.stripes_on   = stripes_q;
  assign state_o.scroll       = scroll_q;

  a_fc_le_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_count_q <= hold_q)
    else $error("frame counter above hold");

  a_hold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q >= HOLD_W'(HOLD_MIN) && hold_q <= HOLD_W'(HOLD_MAX))
    else $error("hold out of range");

  a_scroll_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_i |=> (scroll_q == $past(scroll_q) + 1'b1) || (scroll_q == '0))
    else $error("scroll did not advance");

endmodule

`default_nettype wire

// ----- sv/ssp_pixel.sv -----
// pixel pipeline: row wrap, stripe parity, colour select and brightness scaling
// uses ssp_pkg; palette read data arrives registered, in the cycle after accept
`timescale 1ns / 1ps
`default_nettype none

module ssp_pixel (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       pix_i,
  input  wire  [ssp_pkg::COL_W-1:0] column_i,
  input  wire  [ssp_pkg::ROW_W-1:0] display_row_i,
  input  ssp_pkg::pat_state_t       state_i,
  input  wire  [ssp_pkg::COLOR_W-1:0] color_a_i,
  input  wire  [ssp_pkg::COLOR_W-1:0] color_b_i,
  input  wire                       scale_i,
  output logic                      take_o,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output logic [ssp_pkg::COLOR_W-1:0] pixel_color_o
);
  import ssp_pkg::*;

  typedef struct packed {
    logic [LVL_W-1:0] level_a;
    logic [LVL_W-1:0] level_b;
    logic             phase;
    logic             stripes_on;
  } pick_t;

  logic en1, en2, en3, en4, en5;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  pick_t pk1_q, pk2_q, pk3_q, pk4_q;
  logic [COLOR_W-1:0] ca2_q, cb2_q, ca3_q, cb3_q, ca4_q, cb4_q;
  logic [COL_W-1:0]   x1_q, x2_q;
  logic [SUM_W-1:0]   sum1_q;
  logic [Y_W-1:0]     y2_q;
  logic [STRIPE_W-1:0] s3_q;
  logic [PROD_W-1:0]   prod4_q;
  logic [COLOR_W-1:0]  color5_q;

  logic [SUM_W-1:0]    y_wrap;
  logic [STRIPE_W-1:0] s_d;
  logic [PROD_W-1:0]   prod_d;
  logic                pick_first;
  logic [COLOR_W-1:0]  col_sel;
  logic [LVL_W-1:0]    lvl_sel;
  logic [COLOR_W-1:0]  color_d;

  assign en5 = !v5_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign take_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pix_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_comb begin
    y_wrap = sum1_q;
    for (int i = 0; i < Y_SUBS; i++) begin
      if (y_wrap >= SUM_W'(HEIGHT)) y_wrap = y_wrap - SUM_W'(HEIGHT);
    end
  end

  assign s_d    = STRIPE_W'(x2_q) + STRIPE_W'({x2_q, 1'b0}) + STRIPE_W'({y2_q, 2'b00});
  assign prod_d = PROD_W'(s3_q[STRIPE_W-1:4]) * PROD_W'(RECIP);

  always_comb begin
    pick_first = pk4_q.phase ^ (pk4_q.stripes_on & prod4_q[RECIP_SH]);
    col_sel    = pick_first ? ca4_q : cb4_q;
    lvl_sel    = pick_first ? pk4_q.level_a : pk4_q.level_b;
    color_d    = scale_i ? col_sel * COLOR_W'(lvl_sel) : col_sel;
  end

  always_ff @(posedge clk_i) begin
    if (en1 && pix_i) begin
      x1_q   <= column_i;
      sum1_q <= SUM_W'(display_row_i) + SUM_W'(state_i.scroll) + SUM_W'(ROW_OFS);
      pk1_q  <= '{level_a: state_i.first_level, level_b: state_i.second_level,
                  phase: state_i.phase, stripes_on: state_i.stripes_on};
    end
    if (en2) begin
      x2_q  <= x1_q;
      y2_q  <= y_wrap[Y_W-1:0];
      pk2_q <= pk1_q;
      ca2_q <= color_a_i;
      cb2_q <= color_b_i;
    end
    if (en3) begin
      s3_q  <= s_d;
      pk3_q <= pk2_q;
      ca3_q <= ca2_q;
      cb3_q <= cb2_q;
    end
    if (en4) begin
      prod4_q <= prod_d;
      pk4_q   <= pk3_q;
      ca4_q   <= ca3_q;
      cb4_q   <= cb3_q;
    end
    if (en5) begin
      color5_q <= color_d;
    end
  end

  assign out_valid_o   = v5_q;
  assign pixel_color_o = color5_q;

  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i && en1) |=> v1_q)
    else $error("accepted pixel lost at entry");

  a_bubble_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !v5_q) |=> v5_q)
    else $error("pipeline stuck behind empty output");

  a_y_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> y2_q < Y_W'(HEIGHT))
    else $error("row not wrapped");

endmodule

`default_nettype wire
